>>> design/i2cbe_pkg.sv
package i2cbe_pkg;

   localparam int TICKS_W = 10;
   localparam int LIMIT_W = 16;
   localparam int DELAY_W = 12;
   localparam int CSR_DATA_W = 16;

   localparam logic [TICKS_W-1:0] TICKS_RESET = 10'd50;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd250;

   // configuration register indexes
   localparam logic CSR_TICKS_PER_US = 1'b0;
   localparam logic CSR_ACK_RETRY_LIMIT = 1'b1;

   // request commands
   localparam logic [2:0] CMD_NONE = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_STOP = 3'd2;
   localparam logic [2:0] CMD_SEND_BYTE = 3'd3;
   localparam logic [2:0] CMD_SEND_ACK = 3'd4;
   localparam logic [2:0] CMD_SEND_NACK = 3'd5;

   typedef struct packed {
      logic scl_level;
      logic sda_level;
      logic sda_drive_enable;
      logic busy_res;
      logic done_res;
      logic ack_received;
      logic ack_timeout;
   } res_type;

endpackage

>>> design/i2cbe_csr.sv
module i2cbe_csr
   import i2cbe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic [TICKS_W-1:0]    ticks_per_us,
   output logic [LIMIT_W-1:0]    ack_retry_limit
);

   logic [TICKS_W-1:0] ticks_ff, ticks_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;

   always_comb begin
      ticks_in = ticks_ff;
      limit_in = limit_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_TICKS_PER_US:    ticks_in = csr_data[TICKS_W-1:0];
            CSR_ACK_RETRY_LIMIT: limit_in = csr_data[LIMIT_W-1:0];
            default:             ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= TICKS_RESET;
         limit_ff <= LIMIT_RESET;
      end else begin
         ticks_ff <= ticks_in;
         limit_ff <= limit_in;
      end
   end

   assign ticks_per_us = ticks_ff;
   assign ack_retry_limit = limit_ff;

endmodule

>>> design/i2cbe_engine.sv
module i2cbe_engine
   import i2cbe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [2:0]         req_type,
   input  logic [7:0]         tx_byte,
   input  logic               sda_in,
   input  logic [TICKS_W-1:0] ticks_per_us,
   input  logic [LIMIT_W-1:0] ack_retry_limit,
   output res_type            res
);

   localparam logic [3:0] PH_IDLE    = 4'd0;
   localparam logic [3:0] PH_ST_A    = 4'd1;
   localparam logic [3:0] PH_ST_B    = 4'd2;
   localparam logic [3:0] PH_SP_A    = 4'd3;
   localparam logic [3:0] PH_SP_B    = 4'd4;
   localparam logic [3:0] PH_AK_A    = 4'd5;
   localparam logic [3:0] PH_AK_B    = 4'd6;
   localparam logic [3:0] PH_BT_LOW  = 4'd7;
   localparam logic [3:0] PH_BT_HIGH = 4'd8;
   localparam logic [3:0] PH_BT_TAIL = 4'd9;
   localparam logic [3:0] PH_WT_REL  = 4'd10;
   localparam logic [3:0] PH_WT_CLK  = 4'd11;
   localparam logic [3:0] PH_WT_POLL = 4'd12;
   localparam logic [3:0] PH_TO_A    = 4'd13;
   localparam logic [3:0] PH_TO_B    = 4'd14;

   logic [3:0]         phase_ff, phase_in;
   logic [3:0]         bit_index_ff, bit_index_in;
   logic [7:0]         shift_ff, shift_in;
   logic [DELAY_W-1:0] delay_ff, delay_in;
   logic [LIMIT_W-1:0] retry_ff, retry_in;
   logic               scl_ff, scl_in;
   logic               sda_ff, sda_in_next;
   logic               oe_ff, oe_in;

   logic [TICKS_W-1:0] ticks;
   logic [DELAY_W-1:0] dly_1us, dly_2us, dly_4us;
   logic [DELAY_W-1:0] dly_dec;
   logic [LIMIT_W:0]   retry_next;
   logic [3:0]         bit_next;
   logic               done, ack, tmo;

   // a zero rate counts as one tick per microsecond
   assign ticks = (ticks_per_us == '0) ? TICKS_W'(1) : ticks_per_us;
   assign dly_1us = DELAY_W'(ticks);
   assign dly_2us = DELAY_W'({ticks, 1'b0});
   assign dly_4us = DELAY_W'({ticks, 2'b00});
   assign dly_dec = delay_ff - DELAY_W'(1);
   assign retry_next = {1'b0, retry_ff} + (LIMIT_W+1)'(1);
   assign bit_next = bit_index_ff + 4'd1;

   always_comb begin
      phase_in = phase_ff;
      bit_index_in = bit_index_ff;
      shift_in = shift_ff;
      delay_in = delay_ff;
      retry_in = retry_ff;
      scl_in = scl_ff;
      sda_in_next = sda_ff;
      oe_in = oe_ff;
      done = 1'b0;
      ack = 1'b0;
      tmo = 1'b0;

      if (phase_ff == PH_IDLE) begin
         case (req_type) inside
            CMD_START: begin
               phase_in = PH_ST_A; scl_in = 1'b1; sda_in_next = 1'b1; oe_in = 1'b1;
               delay_in = dly_4us;
            end
            CMD_STOP: begin
               phase_in = PH_SP_A; scl_in = 1'b0; sda_in_next = 1'b0; oe_in = 1'b1;
               delay_in = dly_4us;
            end
            CMD_SEND_BYTE: begin
               shift_in = tx_byte;
               bit_index_in = 4'd0;
               retry_in = '0;
               phase_in = PH_BT_LOW; scl_in = 1'b0; sda_in_next = tx_byte[7];
               oe_in = 1'b1; delay_in = dly_2us;
            end
            CMD_SEND_ACK, CMD_SEND_NACK: begin
               phase_in = PH_AK_A; scl_in = 1'b0; oe_in = 1'b1;
               sda_in_next = (req_type == CMD_SEND_NACK);
               delay_in = dly_2us;
            end
            default: ;
         endcase
      end else if (phase_ff == PH_WT_POLL) begin
         if (!sda_in) begin
            scl_in = 1'b0;
            phase_in = PH_IDLE;
            done = 1'b1;
            ack = 1'b1;
         end else if (retry_next > {1'b0, ack_retry_limit}) begin
            // give up: release the bus with a stop
            phase_in = PH_TO_A; scl_in = 1'b0; sda_in_next = 1'b0; oe_in = 1'b1;
            delay_in = dly_4us;
         end else begin
            retry_in = retry_next[LIMIT_W-1:0];
         end
      end else begin
         delay_in = dly_dec;
         if (dly_dec == '0) begin
            unique case (phase_ff)
               PH_ST_A: begin
                  phase_in = PH_ST_B; scl_in = 1'b1; sda_in_next = 1'b0; oe_in = 1'b1;
                  delay_in = dly_4us;
               end
               PH_ST_B: begin
                  scl_in = 1'b0; phase_in = PH_IDLE; done = 1'b1;
               end
               PH_SP_A: begin
                  phase_in = PH_SP_B; scl_in = 1'b1; sda_in_next = 1'b1; oe_in = 1'b1;
                  delay_in = dly_4us;
               end
               PH_SP_B: begin
                  phase_in = PH_IDLE; done = 1'b1;
               end
               PH_AK_A: begin
                  phase_in = PH_AK_B; scl_in = 1'b1; oe_in = 1'b1; delay_in = dly_2us;
               end
               PH_AK_B: begin
                  scl_in = 1'b0; phase_in = PH_IDLE; done = 1'b1;
               end
               PH_BT_LOW: begin
                  phase_in = PH_BT_HIGH; scl_in = 1'b1; oe_in = 1'b1; delay_in = dly_2us;
               end
               PH_BT_HIGH: begin
                  phase_in = PH_BT_TAIL; scl_in = 1'b0; oe_in = 1'b1; delay_in = dly_2us;
               end
               PH_BT_TAIL: begin
                  shift_in = {shift_ff[6:0], 1'b0};
                  bit_index_in = bit_next;
                  if (bit_next >= 4'd8) begin
                     phase_in = PH_WT_REL; scl_in = 1'b0; sda_in_next = 1'b1; oe_in = 1'b0;
                     delay_in = dly_1us;
                  end else begin
                     phase_in = PH_BT_LOW; scl_in = 1'b0; sda_in_next = shift_ff[6];
                     oe_in = 1'b1; delay_in = dly_2us;
                  end
               end
               PH_WT_REL: begin
                  phase_in = PH_WT_CLK; scl_in = 1'b1; sda_in_next = 1'b1; oe_in = 1'b0;
                  delay_in = dly_1us;
               end
               PH_WT_CLK: begin
                  phase_in = PH_WT_POLL; retry_in = '0;
               end
               PH_TO_A: begin
                  phase_in = PH_TO_B; scl_in = 1'b1; sda_in_next = 1'b1; oe_in = 1'b1;
                  delay_in = dly_4us;
               end
               PH_TO_B: begin
                  phase_in = PH_IDLE; done = 1'b1; tmo = 1'b1;
               end
               default: phase_in = PH_IDLE;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         bit_index_ff <= 4'd0;
         shift_ff <= 8'd0;
         delay_ff <= '0;
         retry_ff <= '0;
         scl_ff <= 1'b1;
         sda_ff <= 1'b1;
         oe_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         bit_index_ff <= bit_index_in;
         shift_ff <= shift_in;
         delay_ff <= delay_in;
         retry_ff <= retry_in;
         scl_ff <= scl_in;
         sda_ff <= sda_in_next;
         oe_ff <= oe_in;
      end
   end

   always_comb begin
      res.scl_level = scl_in;
      res.sda_level = sda_in_next;
      res.sda_drive_enable = oe_in;
      res.busy_res = (phase_in != PH_IDLE);
      res.done_res = done;
      res.ack_received = ack;
      res.ack_timeout = tmo;
   end

endmodule

>>> design/i2c_master_bit_engine_core.sv
// I2C master bit engine: one request is one bus tick, one response per request.
// Path: a request passes through the input register, then the response register;
// the phase sequencer updates as the response register loads.
// Throughput: one request per cycle, limited only by the response handshake.
// Reset (synchronous, active high): sequencer idle, SCL and SDA high, SDA
// released, configuration back to 50 ticks per microsecond and 250 retries.
module i2c_master_bit_engine_core
   import i2cbe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_type,
   input  logic [7:0]            req_tx_byte,
   input  logic                  req_sda_in,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_scl_level,
   output logic                  rsp_sda_level,
   output logic                  rsp_sda_drive_enable,
   output logic                  rsp_busy_res,
   output logic                  rsp_done_res,
   output logic                  rsp_ack_received,
   output logic                  rsp_ack_timeout,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic               in_valid_ff, in_valid_in;
   logic [2:0]         in_type_ff;
   logic [7:0]         in_byte_ff;
   logic               in_sda_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   res_type            rsp_ff;
   res_type            res;
   logic               advance;
   logic               req_fire;
   logic [TICKS_W-1:0] ticks_per_us;
   logic [LIMIT_W-1:0] ack_retry_limit;

   assign csr_ready = 1'b1;

   i2cbe_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .ticks_per_us    (ticks_per_us),
      .ack_retry_limit (ack_retry_limit)
   );

   // advance the held request into the sequencer when the response slot frees
   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire = req_valid && req_ready;
   assign in_valid_in = req_fire || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   i2cbe_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .step            (advance),
      .req_type        (in_type_ff),
      .tx_byte         (in_byte_ff),
      .sda_in          (in_sda_ff),
      .ticks_per_us    (ticks_per_us),
      .ack_retry_limit (ack_retry_limit),
      .res             (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_type_ff <= req_type;
         in_byte_ff <= req_tx_byte;
         in_sda_ff <= req_sda_in;
      end
      if (advance) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_scl_level = rsp_ff.scl_level;
   assign rsp_sda_level = rsp_ff.sda_level;
   assign rsp_sda_drive_enable = rsp_ff.sda_drive_enable;
   assign rsp_busy_res = rsp_ff.busy_res;
   assign rsp_done_res = rsp_ff.done_res;
   assign rsp_ack_received = rsp_ff.ack_received;
   assign rsp_ack_timeout = rsp_ff.ack_timeout;

endmodule

>>> design/i2cbe_checker.sv
module i2cbe_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_scl_level,
   input logic rsp_sda_level,
   input logic rsp_sda_drive_enable,
   input logic rsp_busy_res,
   input logic rsp_done_res,
   input logic rsp_ack_received,
   input logic rsp_ack_timeout
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_scl_level)
         && $stable(rsp_sda_level) && $stable(rsp_sda_drive_enable)
         && $stable(rsp_busy_res) && $stable(rsp_done_res))
      else $error("response changed while stalled");

   // acknowledge status only comes with the finishing tick
   a_status_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_ack_received || rsp_ack_timeout)
         |-> rsp_done_res && !rsp_busy_res && !(rsp_ack_received && rsp_ack_timeout))
      else $error("acknowledge status without completion");

   // a released SDA always reads back high
   a_release_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sda_drive_enable |-> rsp_sda_level)
      else $error("SDA low while released");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind i2c_master_bit_engine_core i2cbe_checker u_i2cbe_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_scl_level        (rsp_scl_level),
   .rsp_sda_level        (rsp_sda_level),
   .rsp_sda_drive_enable (rsp_sda_drive_enable),
   .rsp_busy_res         (rsp_busy_res),
   .rsp_done_res         (rsp_done_res),
   .rsp_ack_received     (rsp_ack_received),
   .rsp_ack_timeout      (rsp_ack_timeout)
);
